@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console character writer: the
// controller state, the controller/datapath command and status groups, the
// control codes and the fixed field widths.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int ROW_W  = 8;
    localparam int OFF_W  = 15;

    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0A;
    localparam logic [ROW_W-1:0]  ROW_MAX    = 8'hFF;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;   // take the character on the input and form its first result
        logic step;   // form the next space of a tab run
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last;   // the result now held is the final one of its character
    } t_dp_stat;

endpackage

@@ rtl/tcw_datapath.sv @@
// ----------------------------------------------------------------------------
// tcw_datapath
// Cursor registers, tab phase and run counter, attribute register and the
// registered result beat. Row base (row * COLUMNS) is kept incrementally.
// ----------------------------------------------------------------------------
module tcw_datapath #(
    parameter int COLUMNS      = 80,
    parameter int VISIBLE_ROWS = 25,
    parameter int TAB_STOP     = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tcw_pkg::t_dp_cmd            i_cmd,
    output tcw_pkg::t_dp_stat           o_stat,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_attr,
    output logic                        o_cell_write,
    output logic [tcw_pkg::OFF_W-1:0]   o_cell_offset,
    output logic [tcw_pkg::CHAR_W-1:0]  o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]  o_cell_attr,
    output logic                        o_on_screen,
    output logic [tcw_pkg::OFF_W-1:0]   o_cursor_offset,
    output logic                        o_last
);

    localparam int COL_W = $clog2(COLUMNS);
    localparam int PH_W  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int CNT_W = $clog2(TAB_STOP + 1);

    localparam logic [COL_W-1:0]          COL_LAST  = COL_W'(COLUMNS - 1);
    localparam logic [COL_W:0]            COL_LIMIT = (COL_W + 1)'(COLUMNS);
    localparam logic [PH_W-1:0]           PH_LAST   = PH_W'(TAB_STOP - 1);
    localparam logic [CNT_W-1:0]          TAB_CNT   = CNT_W'(TAB_STOP);
    localparam logic [tcw_pkg::ROW_W-1:0] VIS_ROWS  = tcw_pkg::ROW_W'(VISIBLE_ROWS);
    localparam logic [tcw_pkg::OFF_W-1:0] BASE_STEP = tcw_pkg::OFF_W'(COLUMNS);

    // cursor state
    logic [COL_W-1:0]          r_col,    n_col;
    logic [PH_W-1:0]           r_phase,  n_phase;
    logic [tcw_pkg::ROW_W-1:0] r_row,    n_row;
    logic [tcw_pkg::OFF_W-1:0] r_base,   n_base;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;
    logic [PH_W-1:0]           r_remain, n_remain;
    logic                      r_last,   n_last;

    // result beat
    logic                       r_wr,    n_wr;
    logic [tcw_pkg::OFF_W-1:0]  r_off,   n_off;
    logic [tcw_pkg::CHAR_W-1:0] r_chr,   n_chr;
    logic [tcw_pkg::ATTR_W-1:0] r_oattr, n_oattr;
    logic                       r_vis,   n_vis;
    logic [tcw_pkg::OFF_W-1:0]  r_cur,   n_cur;

    // shared paths
    logic [tcw_pkg::ROW_W-1:0]  nr_row;
    logic [tcw_pkg::OFF_W-1:0]  nr_base;
    logic [COL_W-1:0]           put_col;
    logic [PH_W-1:0]            put_phase;
    logic [tcw_pkg::ROW_W-1:0]  put_row;
    logic [tcw_pkg::OFF_W-1:0]  put_base;
    logic [tcw_pkg::OFF_W-1:0]  put_off;
    logic                       put_vis;
    logic [CNT_W-1:0]           tab_cnt;
    logic [COL_W:0]             tab_stop;

    always_comb begin
        // next row, saturating
        nr_row  = r_row;
        nr_base = r_base;
        if (r_row != tcw_pkg::ROW_MAX) begin
            nr_row  = r_row + 1'b1;
            nr_base = r_base + BASE_STEP;
        end

        // write at the cursor, then advance
        put_off = r_base + tcw_pkg::OFF_W'(r_col);
        put_vis = (r_row < VIS_ROWS);
        if (r_col == COL_LAST) begin
            put_col   = '0;
            put_phase = '0;
            put_row   = nr_row;
            put_base  = nr_base;
        end else begin
            put_col   = r_col + 1'b1;
            put_phase = (r_phase == PH_LAST) ? '0 : r_phase + 1'b1;
            put_row   = r_row;
            put_base  = r_base;
        end

        tab_cnt  = TAB_CNT - CNT_W'(r_phase);
        tab_stop = {1'b0, r_col} + (COL_W + 1)'(tab_cnt);

        n_col    = r_col;
        n_phase  = r_phase;
        n_row    = r_row;
        n_base   = r_base;
        n_remain = r_remain;
        n_last   = r_last;
        n_wr     = r_wr;
        n_off    = r_off;
        n_chr    = r_chr;
        n_oattr  = r_oattr;
        n_vis    = r_vis;

        if (i_cmd.load) begin
            // non-writing results carry zero cell fields
            n_wr     = 1'b0;
            n_off    = '0;
            n_chr    = '0;
            n_oattr  = '0;
            n_vis    = 1'b0;
            n_remain = '0;
            n_last   = 1'b1;
            case (i_char_code)
                tcw_pkg::CH_NEWLINE: begin
                    n_col   = '0;
                    n_phase = '0;
                    n_row   = nr_row;
                    n_base  = nr_base;
                end
                tcw_pkg::CH_RETURN: begin
                    n_col   = '0;
                    n_phase = '0;
                end
                tcw_pkg::CH_TAB: begin
                    if (tab_stop >= COL_LIMIT) begin
                        n_col   = '0;
                        n_phase = '0;
                        n_row   = nr_row;
                        n_base  = nr_base;
                    end else begin
                        n_wr     = 1'b1;
                        n_off    = put_off;
                        n_chr    = tcw_pkg::CH_SPACE;
                        n_oattr  = r_attr;
                        n_vis    = put_vis;
                        n_col    = put_col;
                        n_phase  = put_phase;
                        n_row    = put_row;
                        n_base   = put_base;
                        n_remain = PH_W'(tab_cnt - 1'b1);
                        n_last   = (tab_cnt == CNT_W'(1));
                    end
                end
                default: begin
                    n_wr    = 1'b1;
                    n_off   = put_off;
                    n_chr   = i_char_code;
                    n_oattr = r_attr;
                    n_vis   = put_vis;
                    n_col   = put_col;
                    n_phase = put_phase;
                    n_row   = put_row;
                    n_base  = put_base;
                end
            endcase
        end else if (i_cmd.step) begin
            n_wr     = 1'b1;
            n_off    = put_off;
            n_chr    = tcw_pkg::CH_SPACE;
            n_oattr  = r_attr;
            n_vis    = put_vis;
            n_col    = put_col;
            n_phase  = put_phase;
            n_row    = put_row;
            n_base   = put_base;
            n_remain = r_remain - 1'b1;
            n_last   = (r_remain == PH_W'(1));
        end

        n_cur = n_base + tcw_pkg::OFF_W'(n_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_phase  <= '0;
            r_row    <= '0;
            r_base   <= '0;
            r_attr   <= tcw_pkg::ATTR_RESET;
            r_remain <= '0;
            r_last   <= 1'b1;
        end else begin
            r_col    <= n_col;
            r_phase  <= n_phase;
            r_row    <= n_row;
            r_base   <= n_base;
            r_remain <= n_remain;
            r_last   <= n_last;
            if (i_cfg_we) begin
                r_attr <= i_cfg_attr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.step) begin
            r_wr    <= n_wr;
            r_off   <= n_off;
            r_chr   <= n_chr;
            r_oattr <= n_oattr;
            r_vis   <= n_vis;
            r_cur   <= n_cur;
        end
    end

    assign o_stat.last     = r_last;
    assign o_cell_write    = r_wr;
    assign o_cell_offset   = r_off;
    assign o_cell_char     = r_chr;
    assign o_cell_attr     = r_oattr;
    assign o_on_screen     = r_vis;
    assign o_cursor_offset = r_cur;
    assign o_last          = r_last;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_LAST)
        else $error("cursor column beyond last column");

    a_phase_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PH_LAST)
        else $error("tab phase out of range");

    a_base_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_base == tcw_pkg::OFF_W'(r_row * COLUMNS))
        else $error("row base out of step with row");

    a_last_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last == (r_remain == '0))
        else $error("last flag disagrees with remaining tab spaces");

    a_step_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> !r_last)
        else $error("tab step issued after final result");

endmodule

@@ rtl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Handshake controller: takes a character, holds each result beat until it
// is taken, steps through tab runs and takes the next character as the
// final beat leaves.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_char_valid,
    output logic               o_char_ready,
    output logic               o_cell_valid,
    input  logic               i_cell_ready,
    output tcw_pkg::t_dp_cmd   o_cmd,
    input  tcw_pkg::t_dp_stat  i_stat
);

    tcw_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_char_ready = 1'b0;
        o_cell_valid = 1'b0;
        o_cmd        = '0;
        case (r_state)
            tcw_pkg::ST_IDLE: begin
                o_char_ready = 1'b1;
                if (i_char_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = tcw_pkg::ST_OUT;
                end
            end
            tcw_pkg::ST_OUT: begin
                o_cell_valid = 1'b1;
                if (i_cell_ready) begin
                    if (!i_stat.last) begin
                        o_cmd.step = 1'b1;
                    end else begin
                        o_char_ready = 1'b1;
                        if (i_char_valid) begin
                            o_cmd.load = 1'b1;
                        end else begin
                            n_state = tcw_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase
    end

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load && o_cmd.step))
        else $error("load and step at once");

    a_step_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step |-> (o_cell_valid && i_cell_ready && !o_char_ready))
        else $error("step without a taken beat");

    a_hold_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cell_valid && !i_cell_ready) |-> (o_cmd == '0))
        else $error("result beat changed while stalled");

endmodule

@@ rtl/text_console_character_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_character_writer
// Teletype output into a text-mode cell array: one character per input
// beat, cursor column and row kept inside, one result beat per cell write
// or cursor move.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                    payload
//   -------   ---------  ---------------------------  ---------------------------
//   char      in         i_char_valid / o_char_ready  i_char_code
//   cell      out        o_cell_valid / i_cell_ready  o_cell_write, o_cell_offset,
//                                                     o_cell_char, o_cell_attr,
//                                                     o_on_screen, o_cursor_offset,
//                                                     o_last
//   cfg       in         i_cfg_valid / o_cfg_ready    i_cfg_text_attribute
//
// A character's first result beat is registered and shows in the cycle after it
// is taken; each further tab space of a tab run adds one more beat. The next
// character is taken in the cycle the final beat leaves, giving one printable
// character per cycle with no stall.
// Reset (synchronous, active low) puts the cursor at row 0, column 0 and the
// attribute at 0x0A. A stall on the cell side holds the current beat and
// blocks the char side until the final beat of the character is taken.
// ----------------------------------------------------------------------------
module text_console_character_writer #(
    parameter int COLUMNS      = 80,
    parameter int VISIBLE_ROWS = 25,
    parameter int TAB_STOP     = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // character input
    input  logic                        i_char_valid,
    output logic                        o_char_ready,
    input  logic [tcw_pkg::CHAR_W-1:0]  i_char_code,
    // cell result output
    output logic                        o_cell_valid,
    input  logic                        i_cell_ready,
    output logic                        o_cell_write,
    output logic [tcw_pkg::OFF_W-1:0]   o_cell_offset,
    output logic [tcw_pkg::CHAR_W-1:0]  o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]  o_cell_attr,
    output logic                        o_on_screen,
    output logic [tcw_pkg::OFF_W-1:0]   o_cursor_offset,
    output logic                        o_last,
    // attribute register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_text_attribute
);

    tcw_pkg::t_dp_cmd  w_cmd;
    tcw_pkg::t_dp_stat w_stat;

    // The attribute register accepts a beat in any cycle.
    assign o_cfg_ready = 1'b1;

    // Handshakes and sequencing of tab runs.
    tcw_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_valid (i_char_valid),
        .o_char_ready (o_char_ready),
        .o_cell_valid (o_cell_valid),
        .i_cell_ready (i_cell_ready),
        .o_cmd        (w_cmd),
        .i_stat       (w_stat)
    );

    // Cursor, attribute and the registered result beat.
    tcw_datapath #(
        .COLUMNS      (COLUMNS),
        .VISIBLE_ROWS (VISIBLE_ROWS),
        .TAB_STOP     (TAB_STOP)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_char_code     (i_char_code),
        .i_cfg_we        (i_cfg_valid & o_cfg_ready),
        .i_cfg_attr      (i_cfg_text_attribute),
        .o_cell_write    (o_cell_write),
        .o_cell_offset   (o_cell_offset),
        .o_cell_char     (o_cell_char),
        .o_cell_attr     (o_cell_attr),
        .o_on_screen     (o_on_screen),
        .o_cursor_offset (o_cursor_offset),
        .o_last          (o_last)
    );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text console character writer. A driver feeds
// character beats from a pending queue, a predictor keeps its own cursor and
// attribute and queues the cell beats each character must produce, and a
// monitor checks every cell beat against the oldest queued one. Both sides
// idle at random. The run steps through attribute settings and a run of
// newlines that drives the row past the visible area.
// ----------------------------------------------------------------------------
module tb;

    localparam int COLUMNS      = 80;
    localparam int VISIBLE_ROWS = 25;
    localparam int TAB_STOP     = 8;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 20;

    // One beat on the cell channel, in port order.
    typedef struct packed {
        logic                      write;
        logic [tcw_pkg::OFF_W-1:0] cell_off;
        logic [7:0]                char_code;
        logic [7:0]                attr;
        logic                      on_screen;
        logic [tcw_pkg::OFF_W-1:0] cursor_off;
        logic                      last;
    } t_cell_beat;

    logic                       i_clk                = 1'b0;
    logic                       i_rst_n              = 1'b0;
    logic                       i_char_valid         = 1'b0;
    logic [tcw_pkg::CHAR_W-1:0] i_char_code          = '0;
    logic                       i_cell_ready         = 1'b0;
    logic                       i_cfg_valid          = 1'b0;
    logic [tcw_pkg::ATTR_W-1:0] i_cfg_text_attribute = '0;
    logic                       o_char_ready;
    logic                       o_cell_valid;
    logic                       o_cell_write;
    logic [tcw_pkg::OFF_W-1:0]  o_cell_offset;
    logic [tcw_pkg::CHAR_W-1:0] o_cell_char;
    logic [tcw_pkg::ATTR_W-1:0] o_cell_attr;
    logic                       o_on_screen;
    logic [tcw_pkg::OFF_W-1:0]  o_cursor_offset;
    logic                       o_last;
    logic                       o_cfg_ready;

    // Predicted console state: cursor and the current attribute byte.
    logic [6:0]                 cur_col  = '0;
    logic [tcw_pkg::ROW_W-1:0]  cur_row  = '0;
    logic [tcw_pkg::ATTR_W-1:0] cur_attr = tcw_pkg::ATTR_RESET;

    logic [tcw_pkg::CHAR_W-1:0] pending_chars[$];
    t_cell_beat                 expected_cells[$];
    int                         mismatches = 0;

    // Handshake pacing for each side.
    int   char_wait  = 0;
    int   char_quiet = 0;
    int   cell_wait  = 0;
    int   cell_quiet = 0;
    logic char_present;
    logic cell_take;

    text_console_character_writer #(
        .COLUMNS      (COLUMNS),
        .VISIBLE_ROWS (VISIBLE_ROWS),
        .TAB_STOP     (TAB_STOP)
    ) u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_char_valid         (i_char_valid),
        .o_char_ready         (o_char_ready),
        .i_char_code          (i_char_code),
        .o_cell_valid         (o_cell_valid),
        .i_cell_ready         (i_cell_ready),
        .o_cell_write         (o_cell_write),
        .o_cell_offset        (o_cell_offset),
        .o_cell_char          (o_cell_char),
        .o_cell_attr          (o_cell_attr),
        .o_on_screen          (o_on_screen),
        .o_cursor_offset      (o_cursor_offset),
        .o_last               (o_last),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_text_attribute (i_cfg_text_attribute)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic logic [tcw_pkg::OFF_W-1:0] cursor_cell();
        return tcw_pkg::OFF_W'(int'(cur_row) * COLUMNS + int'(cur_col));
    endfunction

    // Advance one row; the row sticks at its maximum, there is no scrolling.
    function automatic void advance_row();
        if (cur_row != tcw_pkg::ROW_MAX)
            cur_row = cur_row + 1'b1;
    endfunction

    // Queue a beat; the cursor field is always the cursor as it now stands.
    function automatic void push_cell(logic wr, logic [tcw_pkg::OFF_W-1:0] off,
                                      logic [7:0] code, logic [7:0] attr,
                                      logic vis, logic last);
        t_cell_beat beat;
        beat = '{write: wr, cell_off: off, char_code: code, attr: attr,
                 on_screen: vis, cursor_off: cursor_cell(), last: last};
        expected_cells.push_back(beat);
    endfunction

    // Write at the cursor, then step it on, wrapping at the right margin.
    function automatic void write_cell(logic [7:0] code, logic last);
        logic [tcw_pkg::OFF_W-1:0] off;
        logic                      vis;
        off = cursor_cell();
        vis = (int'(cur_row) < VISIBLE_ROWS);
        if (int'(cur_col) + 1 >= COLUMNS) begin
            cur_col = '0;
            advance_row();
        end else begin
            cur_col = cur_col + 1'b1;
        end
        push_cell(1'b1, off, code, cur_attr, vis, last);
    endfunction

    // Work out every cell beat that one character causes.
    function automatic void predict_cells(logic [tcw_pkg::CHAR_W-1:0] code);
        int stop;
        int spaces;
        case (code)
            tcw_pkg::CH_NEWLINE: begin
                cur_col = '0;
                advance_row();
                push_cell(1'b0, '0, '0, '0, 1'b0, 1'b1);
            end
            tcw_pkg::CH_RETURN: begin
                cur_col = '0;
                push_cell(1'b0, '0, '0, '0, 1'b0, 1'b1);
            end
            tcw_pkg::CH_TAB: begin
                stop = int'(cur_col) + TAB_STOP - int'(cur_col) % TAB_STOP;
                if (stop >= COLUMNS) begin
                    // tab past the last stop: new line, nothing written
                    cur_col = '0;
                    advance_row();
                    push_cell(1'b0, '0, '0, '0, 1'b0, 1'b1);
                end else begin
                    spaces = stop - int'(cur_col);
                    for (int i = 0; i < spaces; i++)
                        write_cell(tcw_pkg::CH_SPACE, i == spaces - 1);
                end
            end
            default: write_cell(code, 1'b1);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Per-beat random wait, with occasional quiet runs of no waiting.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left == 0 && $urandom_range(0, 15) == 0)
            quiet_left = $urandom_range(8, 30);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [7:0] random_printable();
        logic [7:0] code;
        do
            code = 8'($urandom_range(0, 255));
        while (code == tcw_pkg::CH_TAB || code == tcw_pkg::CH_NEWLINE ||
               code == tcw_pkg::CH_RETURN);
        return code;
    endfunction

    // Text with control codes mixed in; nl_pct sets how often lines end.
    function automatic void queue_text(int count, int nl_pct);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < nl_pct)
                pending_chars.push_back(tcw_pkg::CH_NEWLINE);
            else if (pick < nl_pct + 5)
                pending_chars.push_back(tcw_pkg::CH_RETURN);
            else if (pick < nl_pct + 17)
                pending_chars.push_back(tcw_pkg::CH_TAB);
            else
                pending_chars.push_back(random_printable());
        end
    endfunction

    // Hold until every queued character has gone in and every beat is back.
    // Sample on the falling edge so the edge's own updates have settled.
    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_chars.size() != 0 || i_char_valid || expected_cells.size() != 0);
    endtask

    task automatic write_attribute(logic [tcw_pkg::ATTR_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid          <= 1'b1;
        i_cfg_text_attribute <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        cur_attr = value;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic string show_beat(t_cell_beat b);
        return $sformatf("wr=%0d off=%0d ch=%02h attr=%02h vis=%0d cur=%0d last=%0d",
                         b.write, b.cell_off, b.char_code, b.attr, b.on_screen,
                         b.cursor_off, b.last);
    endfunction

    function automatic void note_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------------
    // Character driver: present the next pending beat once its wait is over,
    // and predict each beat as it is taken.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            char_wait = 0;
            i_char_valid <= 1'b0;
        end else begin
            char_present = i_char_valid;
            if (i_char_valid && o_char_ready) begin
                predict_cells(i_char_code);
                char_present = 1'b0;
            end
            if (!char_present) begin
                if (char_wait > 0) begin
                    char_wait--;
                end else if (pending_chars.size() != 0) begin
                    i_char_code <= pending_chars.pop_front();
                    char_present = 1'b1;
                    char_wait    = draw_wait(char_quiet);
                end
            end
            // single update of valid per edge, so a held beat never glitches
            i_char_valid <= char_present;
        end
    end

    // ------------------------------------------------------------------------
    // Cell monitor: check each taken beat against the oldest expectation, then
    // drop ready for a drawn number of cycles.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_wait = 0;
            i_cell_ready <= 1'b0;
        end else begin
            cell_take = i_cell_ready;
            if (o_cell_valid && i_cell_ready) begin
                t_cell_beat seen;
                t_cell_beat want;
                seen = '{write: o_cell_write, cell_off: o_cell_offset,
                         char_code: o_cell_char, attr: o_cell_attr,
                         on_screen: o_on_screen, cursor_off: o_cursor_offset,
                         last: o_last};
                if (expected_cells.size() == 0) begin
                    note_failure({"unexpected cell beat: ", show_beat(seen)});
                end else begin
                    want = expected_cells.pop_front();
                    if (seen !== want)
                        note_failure({"cell beat differs\n  expected ", show_beat(want),
                                      "\n  actual   ", show_beat(seen)});
                end
                cell_wait = draw_wait(cell_quiet);
                cell_take = (cell_wait == 0);
            end else if (!i_cell_ready) begin
                if (cell_wait > 0)
                    cell_wait--;
                cell_take = (cell_wait == 0);
            end
            i_cell_ready <= cell_take;
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        for (int n = 0; n < CYCLE_LIMIT; n++)
            @(posedge i_clk);
        $display("text_console_character_writer: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------------
    initial begin
        // Directed opening on the reset attribute: extreme codes, code zero,
        // tabs from several columns, a tab at the last stop and line controls.
        pending_chars.push_back(8'h00);
        pending_chars.push_back(8'hFF);
        pending_chars.push_back(8'h55);
        pending_chars.push_back(tcw_pkg::CH_TAB);     // five spaces
        pending_chars.push_back(8'hAA);
        pending_chars.push_back(tcw_pkg::CH_RETURN);
        for (int i = 0; i < 9; i++)
            pending_chars.push_back(tcw_pkg::CH_TAB); // full tab runs up to column 72
        pending_chars.push_back(8'h01);
        pending_chars.push_back(8'h02);
        pending_chars.push_back(8'h7E);
        pending_chars.push_back(8'h80);
        pending_chars.push_back(8'hFE);
        pending_chars.push_back(tcw_pkg::CH_SPACE);
        pending_chars.push_back(8'h41);               // next to last column
        pending_chars.push_back(tcw_pkg::CH_TAB);     // past the last stop: wraps
        pending_chars.push_back(tcw_pkg::CH_NEWLINE);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Random lines on visible rows with a zero attribute.
        wait_drained();
        write_attribute(8'h00);
        queue_text(20, 8);

        // Full attribute: walk down to the last visible row, write across the
        // visible edge, then tab to column 72 and print over the margin.
        wait_drained();
        write_attribute(8'hFF);
        for (int r = int'(cur_row); r < VISIBLE_ROWS - 1; r++)
            pending_chars.push_back(tcw_pkg::CH_NEWLINE);
        queue_text(10, 0);
        pending_chars.push_back(tcw_pkg::CH_NEWLINE);
        queue_text(10, 0);
        pending_chars.push_back(tcw_pkg::CH_RETURN);
        for (int i = 0; i < 9; i++)
            pending_chars.push_back(tcw_pkg::CH_TAB);
        for (int i = 0; i < 8; i++)
            pending_chars.push_back(random_printable());

        // Random attribute and a short run of text that rarely ends a line.
        wait_drained();
        write_attribute(8'($urandom_range(1, 254)));
        queue_text(10, 1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_cells.size() != 0)
            note_failure($sformatf("%0d cell beats never arrived", expected_cells.size()));

        if (mismatches == 0)
            $display("text_console_character_writer: match");
        else
            $display("text_console_character_writer: mismatch");
        $finish;
    end

endmodule
